// ----- hw/rtl/hpetb_pkg.sv -----
package hpetb_pkg;

   localparam int unsigned ReqDataW = 48;
   localparam int unsigned ReqUserW = 2;
   localparam int unsigned RspDataW = 40;
   localparam int unsigned PeriodW  = 27;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;

   localparam logic [0:0] CSR_TICK_PERIOD = 1'b0;
   localparam logic [0:0] CSR_PERIODIC_CAP = 1'b1;

   localparam logic [8:0] REG_CAP    = 9'h000;
   localparam logic [8:0] REG_PERIOD = 9'h004;
   localparam logic [8:0] REG_GCONF  = 9'h010;
   localparam logic [8:0] REG_CNT_LO = 9'h0F0;
   localparam logic [8:0] REG_CNT_HI = 9'h0F4;
   localparam logic [8:0] REG_TCONF  = 9'h100;
   localparam logic [8:0] REG_CMP_LO = 9'h108;
   localparam logic [8:0] REG_CMP_HI = 9'h10C;

   localparam logic [31:0] CAP_WORD = 32'h0000_2001;

   localparam logic [PeriodW-1:0] TICK_PERIOD_RESET = 27'd69841279;

   typedef struct packed {
      logic [1:0]  op;
      logic [8:0]  addr;
      logic [31:0] wdata;
   } item_type;

   typedef struct packed {
      logic [31:0] rdata;
      logic        irq;
   } result_type;

   typedef struct packed {
      logic               valid;
      logic [0:0]         index;
      logic [PeriodW-1:0] data;
   } cfg_wr_type;

endpackage

// ----- hw/rtl/hpet_timer_block.sv -----
// A transaction accepted on req_ is held in the input register, then in the result
// register that drives rsp_; a stall on rsp_tready can hold it in either register.
// Throughput: one transaction per cycle; the input register, the register update
// logic and the result register form a two-stage pipe, stalled only by rsp_tready.
// Reset (synchronous, active high) empties both stages, clears the counter, enables
// and timer flags, sets the comparator to all ones and restores the tick period
// and periodic capability to their defaults. csr_ready is always high.
module hpet_timer_block (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [8:0] addr, [40:9] wdata, [47:41] zero
   input  logic [hpetb_pkg::ReqDataW-1:0] req_tdata,
   // [1:0] op
   input  logic [hpetb_pkg::ReqUserW-1:0] req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [31:0] rdata, [32] irq, [39:33] zero
   output logic [hpetb_pkg::RspDataW-1:0] rsp_tdata,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [0:0]                     csr_index,
   input  logic [hpetb_pkg::PeriodW-1:0]  csr_wdata
);

   logic                  item_valid;
   hpetb_pkg::item_type   item;
   hpetb_pkg::result_type result;
   hpetb_pkg::cfg_wr_type cfg_wr;
   logic                  can_load;
   logic                  step;

   assign csr_ready    = 1'b1;
   assign cfg_wr.valid = csr_valid;
   assign cfg_wr.index = csr_index;
   assign cfg_wr.data  = csr_wdata;

   assign step = item_valid && can_load;

   hpetb_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .advance    (can_load),
      .item_valid (item_valid),
      .item       (item)
   );

   hpetb_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg_wr (cfg_wr),
      .step   (step),
      .item   (item),
      .result (result)
   );

   hpetb_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (step),
      .result     (result),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- hw/rtl/hpetb_in_reg.sv -----
module hpetb_in_reg (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [hpetb_pkg::ReqDataW-1:0] req_tdata,
   input  logic [hpetb_pkg::ReqUserW-1:0] req_tuser,
   input  logic                          advance,
   output logic                          item_valid,
   output hpetb_pkg::item_type           item
);

   logic                valid_ff;
   logic                valid_in;
   hpetb_pkg::item_type item_ff;
   hpetb_pkg::item_type item_in;
   logic                take;

   assign req_tready = !valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (take) begin
         valid_in      = 1'b1;
         item_in.op    = req_tuser[1:0];
         item_in.addr  = req_tdata[8:0];
         item_in.wdata = req_tdata[40:9];
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ----- hw/rtl/hpetb_core.sv -----
module hpetb_core (
   input  logic                   clock,
   input  logic                   reset,
   input  hpetb_pkg::cfg_wr_type  cfg_wr,
   input  logic                   step,
   input  hpetb_pkg::item_type    item,
   output hpetb_pkg::result_type  result
);

   logic [hpetb_pkg::PeriodW-1:0] period_ff, period_in;
   logic        per_cap_ff, per_cap_in;
   logic [63:0] count_ff, count_in;
   logic [1:0]  gen_ff, gen_in;
   logic [2:0]  flags_ff, flags_in;
   logic [63:0] cmp_ff, cmp_in;
   logic [63:0] reload_ff, reload_in;

   logic [8:0]  word_addr;
   logic [63:0] count_inc;
   logic [63:0] cmp_next;
   logic        periodic_on;
   logic        match;
   logic [31:0] read_val;

   assign word_addr   = {item.addr[8:2], 2'b00};
   assign count_inc   = count_ff + 64'd1;
   assign cmp_next    = cmp_ff + reload_ff;
   assign periodic_on = flags_ff[1] && per_cap_ff;
   assign match       = (count_inc == cmp_ff);

   always_comb begin
      period_in = period_ff;
      per_cap_in = per_cap_ff;
      if (cfg_wr.valid) begin
         unique case (cfg_wr.index)
            hpetb_pkg::CSR_TICK_PERIOD: period_in = cfg_wr.data;
            hpetb_pkg::CSR_PERIODIC_CAP: per_cap_in = cfg_wr.data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (word_addr)
         hpetb_pkg::REG_CAP:    read_val = hpetb_pkg::CAP_WORD;
         hpetb_pkg::REG_PERIOD: read_val = {5'd0, period_ff};
         hpetb_pkg::REG_GCONF:  read_val = {30'd0, gen_ff};
         hpetb_pkg::REG_CNT_LO: read_val = count_ff[31:0];
         hpetb_pkg::REG_CNT_HI: read_val = count_ff[63:32];
         hpetb_pkg::REG_TCONF:  read_val = {26'd0, 1'b1, per_cap_ff, periodic_on,
                                           flags_ff[0], 2'b00};
         hpetb_pkg::REG_CMP_LO: read_val = cmp_ff[31:0];
         hpetb_pkg::REG_CMP_HI: read_val = cmp_ff[63:32];
         default:               read_val = 32'd0;
      endcase
   end

   always_comb begin
      count_in     = count_ff;
      gen_in       = gen_ff;
      flags_in     = flags_ff;
      cmp_in       = cmp_ff;
      reload_in    = reload_ff;
      result.rdata = 32'd0;
      result.irq   = 1'b0;
      if (step) begin
         unique case (item.op)
            hpetb_pkg::OP_TICK: begin
               if (gen_ff[0]) begin
                  count_in = count_inc;
                  if (match) begin
                     result.irq = flags_ff[0] && gen_ff[1];
                     if (periodic_on) begin
                        cmp_in = cmp_next;
                     end
                  end
               end
            end
            hpetb_pkg::OP_READ: begin
               result.rdata = read_val;
            end
            hpetb_pkg::OP_WRITE: begin
               unique case (word_addr)
                  hpetb_pkg::REG_GCONF:  gen_in = item.wdata[1:0];
                  hpetb_pkg::REG_CNT_LO: count_in[31:0] = item.wdata;
                  hpetb_pkg::REG_CNT_HI: count_in[63:32] = item.wdata;
                  hpetb_pkg::REG_TCONF: begin
                     flags_in = {item.wdata[6], item.wdata[3] && per_cap_ff, item.wdata[2]};
                  end
                  hpetb_pkg::REG_CMP_LO: begin
                     cmp_in[31:0] = item.wdata;
                     if (periodic_on) begin
                        reload_in[31:0] = item.wdata;
                     end
                     flags_in[2] = 1'b0;
                  end
                  hpetb_pkg::REG_CMP_HI: begin
                     cmp_in[63:32] = item.wdata;
                     if (periodic_on) begin
                        reload_in[63:32] = item.wdata;
                     end
                     flags_in[2] = 1'b0;
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff  <= hpetb_pkg::TICK_PERIOD_RESET;
         per_cap_ff <= 1'b1;
         count_ff   <= 64'd0;
         gen_ff     <= 2'd0;
         flags_ff   <= 3'd0;
         cmp_ff     <= '1;
         reload_ff  <= 64'd0;
      end else begin
         period_ff  <= period_in;
         per_cap_ff <= per_cap_in;
         count_ff   <= count_in;
         gen_ff     <= gen_in;
         flags_ff   <= flags_in;
         cmp_ff     <= cmp_in;
         reload_ff  <= reload_in;
      end
   end

endmodule

// ----- hw/rtl/hpetb_out_reg.sv -----
module hpetb_out_reg (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           load,
   input  hpetb_pkg::result_type          result,
   output logic                           can_load,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [hpetb_pkg::RspDataW-1:0] rsp_tdata
);

   logic                  valid_ff, valid_in;
   hpetb_pkg::result_type res_ff, res_in;

   assign can_load = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      res_in   = res_ff;
      if (load) begin
         valid_in = 1'b1;
         res_in   = result;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      res_ff <= res_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {7'd0, res_ff.irq, res_ff.rdata};

endmodule

// ----- hw/rtl/hpetb_checker.sv -----
module hpetb_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [hpetb_pkg::RspDataW-1:0] rsp_tdata
);

   // An interrupt only comes from a tick, and ticks return no read data.
   a_irq_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[32]) |-> (rsp_tdata[31:0] == 32'd0))
      else $error("irq reported together with read data");

   // The input side only stalls when a result is waiting to be taken.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("input stalled without a pending result");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("pipeline not empty after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

endmodule

bind hpet_timer_block hpetb_checker u_hpetb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
